// File: rtl/eased_tween_interpolator_macros.svh
// ---------------------------------------------------------------------------
// eased tween interpolator assertion macros
// shared property shapes for the checks in the rtl
// ---------------------------------------------------------------------------
`ifndef EASED_TWEEN_INTERPOLATOR_MACROS_SVH
`define EASED_TWEEN_INTERPOLATOR_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define ETW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define ETW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/etw_pkg.sv
// ---------------------------------------------------------------------------
// etw_pkg
// shared constants, transaction kinds and flag type of the tween interpolator
// ---------------------------------------------------------------------------
package etw_pkg;

    localparam int VALUE_BITS_DEF    = 32;
    localparam int DURATION_BITS_DEF = 20;
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int PAUSE_BITS        = 20;
    localparam int CLOCK_BITS        = 32;
    localparam int QUEUE_DEPTH       = 2;

    // input modes
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_ADD  = 2'd2;
    localparam logic [1:0] MODE_MOVE = 2'd3;

    // curves
    localparam logic [1:0] CURVE_LINEAR   = 2'd0;
    localparam logic [1:0] CURVE_EASE_IN  = 2'd1;
    localparam logic [1:0] CURVE_EASE_OUT = 2'd2;
    localparam logic [1:0] CURVE_ELASTIC  = 2'd3;

    // classified transaction kinds
    localparam int KIND_BITS = 3;
    localparam logic [KIND_BITS-1:0] KIND_TICK = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_SET  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_ADD  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_NONE = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_MOVE = 3'd4;

    typedef struct packed {
        logic moved;
        logic finished;
        logic done;
    } t_flags;

endpackage

// File: rtl/etw_front.sv
// ---------------------------------------------------------------------------
// etw_front
// input register stage that classifies each transaction for the back end
// ---------------------------------------------------------------------------
module etw_front
    import etw_pkg::*;
#(
    parameter int VALUE_BITS    = VALUE_BITS_DEF,
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_mode,
    input  logic [1:0]                    i_curve,
    input  logic signed [VALUE_BITS-1:0]  i_amount,
    input  logic [DURATION_BITS-1:0]      i_duration_ms,
    input  logic [PAUSE_BITS-1:0]         i_pause_ms,
    output logic                          o_push,
    input  logic                          i_full,
    output logic [KIND_BITS-1:0]          o_kind,
    output logic [1:0]                    o_curve,
    output logic signed [VALUE_BITS-1:0]  o_amount,
    output logic [DURATION_BITS-1:0]      o_duration,
    output logic [PAUSE_BITS-1:0]         o_pause
);

    logic                         r_valid;
    logic                         n_valid;
    logic [KIND_BITS-1:0]         r_kind;
    logic [KIND_BITS-1:0]         n_kind;
    logic                         accept;

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign accept  = i_valid && !o_stall;
    assign o_kind  = r_kind;

    always_comb begin
        n_kind = r_kind;
        if (accept) begin
            case (i_mode)
                MODE_TICK: n_kind = KIND_TICK;
                MODE_SET:  n_kind = KIND_SET;
                MODE_ADD:  n_kind = (i_amount == '0) ? KIND_NONE : KIND_ADD;
                MODE_MOVE: n_kind = (i_duration_ms == '0) ? KIND_SET : KIND_MOVE;
                default:   n_kind = KIND_NONE;
            endcase
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        if (accept) begin
            o_curve    <= i_curve;
            o_amount   <= i_amount;
            o_duration <= i_duration_ms;
            o_pause    <= i_pause_ms;
        end
    end

endmodule

// File: rtl/etw_queue.sv
// ---------------------------------------------------------------------------
// etw_queue
// short first-in first-out queue between front and back
// ---------------------------------------------------------------------------
module etw_queue
    import etw_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/etw_back.sv
// ---------------------------------------------------------------------------
// etw_back
// tween state, progress, shared divider, curve steps and output register
// ---------------------------------------------------------------------------
`include "eased_tween_interpolator_macros.svh"

module etw_back
    import etw_pkg::*;
#(
    parameter int VALUE_BITS    = VALUE_BITS_DEF,
    parameter int DURATION_BITS = DURATION_BITS_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  logic [KIND_BITS-1:0]          i_kind,
    input  logic [1:0]                    i_curve,
    input  logic signed [VALUE_BITS-1:0]  i_amount,
    input  logic [DURATION_BITS-1:0]      i_duration,
    input  logic [PAUSE_BITS-1:0]         i_pause,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_BITS-1:0]  o_current,
    output logic signed [VALUE_BITS-1:0]  o_target,
    output t_flags                        o_flags
);

    localparam int VB        = VALUE_BITS;
    localparam int DB        = DURATION_BITS;
    localparam int MB        = VB + 1;
    localparam int LO        = (MB + 1) / 2;
    localparam int AW        = MB + 32;
    localparam int RW        = AW - 30;
    localparam int SW        = RW + 2;
    localparam int IW        = $clog2(TABLE_ENTRIES);
    localparam int JW        = $clog2(TABLE_ENTRIES + 1);
    localparam int MNW       = 30 + JW + 1;
    localparam int DIV_STEPS = 30;

    localparam longint Q_ONE     = 64'sd1073741824;
    localparam longint Q_PI      = 64'sd3373259426;
    localparam longint Q_HALF_PI = 64'sd1686629713;
    localparam longint Q_TWO_PI  = 64'sd6746518852;
    localparam longint Q_LN2     = 64'sd744261118;

    // series denominators: (2k)(2k+1) for the sine, k for the exponential
    localparam longint SIN_DIV [8]  = '{1, 6, 20, 42, 72, 110, 156, 210};
    localparam longint EXP_DIV [13] = '{1, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12};

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CMD     = 5'd1;
    localparam logic [4:0] S_FLAGS   = 5'd2;
    localparam logic [4:0] S_EV0     = 5'd3;
    localparam logic [4:0] S_DIV     = 5'd4;
    localparam logic [4:0] S_CURVE   = 5'd5;
    localparam logic [4:0] S_C1      = 5'd6;
    localparam logic [4:0] S_C2      = 5'd7;
    localparam logic [4:0] S_C3      = 5'd8;
    localparam logic [4:0] S_C4      = 5'd9;
    localparam logic [4:0] S_C5      = 5'd10;
    localparam logic [4:0] S_C6      = 5'd11;
    localparam logic [4:0] S_SCALE0  = 5'd12;
    localparam logic [4:0] S_SCALE1  = 5'd13;
    localparam logic [4:0] S_SCALE2  = 5'd14;
    localparam logic [4:0] S_SCALE3  = 5'd15;
    localparam logic [4:0] S_SCALE4  = 5'd16;
    localparam logic [4:0] S_EV_DONE = 5'd17;

    typedef logic signed [31:0] t_sine_tab [TABLE_ENTRIES];
    typedef logic [30:0]        t_exp_tab  [TABLE_ENTRIES + 1];

    // quarter-wave taylor sine in q30
    function automatic longint sin_q30(input longint xin);
        longint x;
        longint term;
        longint sum;
        logic   neg;
        x   = xin;
        neg = 1'b0;
        if (x >= Q_PI) begin
            x   = x - Q_PI;
            neg = 1'b1;
        end
        if (x > Q_HALF_PI) begin
            x = Q_PI - x;
        end
        term = x;
        sum  = x;
        for (int k = 1; k <= 7; k++) begin
            term = term * x / Q_ONE;
            term = term * x / Q_ONE;
            term = -term / SIN_DIV[k];
            sum  = sum + term;
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > Q_ONE) begin
            sum = Q_ONE;
        end
        return neg ? -sum : sum;
    endfunction

    // 2^(-10 j / n) in q30, series for the fraction and a rounded shift
    function automatic longint exp2neg_q30(input longint j);
        longint e;
        longint ip;
        longint fr;
        longint y;
        longint term;
        longint sum;
        e    = 10 * j;
        ip   = e / TABLE_ENTRIES;
        fr   = e % TABLE_ENTRIES;
        y    = Q_LN2 * fr / TABLE_ENTRIES;
        term = Q_ONE;
        sum  = Q_ONE;
        for (int k = 1; k <= 12; k++) begin
            term = -(term * y / Q_ONE) / EXP_DIV[k];
            sum  = sum + term;
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (ip > 0) begin
            sum = (sum + (64'sd1 <<< (ip - 1))) >>> ip;
        end
        return sum;
    endfunction

    function automatic t_sine_tab build_sine();
        t_sine_tab t;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            t[i] = 32'(sin_q30(Q_TWO_PI * longint'(i) / TABLE_ENTRIES));
        end
        return t;
    endfunction

    function automatic t_exp_tab build_exp();
        t_exp_tab t;
        for (int i = 0; i <= TABLE_ENTRIES; i++) begin
            t[i] = 31'(exp2neg_q30(longint'(i)));
        end
        return t;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();
    localparam t_exp_tab  EXP_TAB  = build_exp();

    localparam logic signed [VB-1:0] VAL_MAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VAL_MIN = {1'b1, {(VB-1){1'b0}}};
    localparam logic signed [SW-1:0] WIDE_MAX = {{(SW-VB+1){1'b0}}, {(VB-1){1'b1}}};
    localparam logic signed [SW-1:0] WIDE_MIN = {{(SW-VB+1){1'b1}}, {(VB-1){1'b0}}};

    // control state
    logic [4:0]             r_state, n_state;
    logic                   r_move, n_move;
    // tween state
    logic [CLOCK_BITS-1:0]  r_clock, n_clock;
    logic [CLOCK_BITS-1:0]  r_start, n_start;
    logic [DB-1:0]          r_len, n_len;
    logic [1:0]             r_curve, n_curve;
    logic signed [VB-1:0]   r_from, n_from;
    logic signed [VB-1:0]   r_to, n_to;
    logic                   r_force, n_force;
    logic [DB-1:0]          r_last, n_last;
    logic                   r_fseen, n_fseen;
    // transaction held by the sequencer
    logic [KIND_BITS-1:0]   r_kind, n_kind;
    logic [1:0]             r_icurve, n_icurve;
    logic signed [VB-1:0]   r_amt, n_amt;
    logic [DB-1:0]          r_dur, n_dur;
    logic [PAUSE_BITS-1:0]  r_pause, n_pause;
    t_flags                 r_flags, n_flags;
    // evaluation datapath
    logic [DB-1:0]          r_rem, n_rem;
    logic [29:0]            r_quo, n_quo;
    logic [4:0]             r_cnt, n_cnt;
    logic [31:0]            r_opa, n_opa;
    logic [31:0]            r_opb, n_opb;
    logic [63:0]            r_prod, n_prod;
    logic [31:0]            r_k, n_k;
    logic [29:0]            r_m, n_m;
    logic [IW-1:0]          r_idx, n_idx;
    logic [JW-1:0]          r_j, n_j;
    logic                   r_sneg, n_sneg;
    logic                   r_neg, n_neg;
    logic [MB-1:0]          r_mag, n_mag;
    logic [AW-1:0]          r_acc, n_acc;
    logic signed [VB-1:0]   r_result, n_result;
    // output register
    logic                   r_out_valid;
    logic                   out_load;
    logic                   out_free;

    // progress
    logic [CLOCK_BITS-1:0]  prog_d;
    logic [DB-1:0]          p_now;
    // divider step
    logic [DB:0]            div_sh;
    logic [DB:0]            div_sub;
    logic                   div_ge;
    // curve helpers
    logic [30:0]            w_val;
    logic [63:0]            prod_rnd;
    logic [33:0]            el_v;
    logic [MNW-1:0]         idx_scaled;
    logic [MNW-1:0]         j_scaled;
    logic [JW:0]            idx_full;
    logic [JW:0]            j_full;
    logic [31:0]            sine_mag;
    logic [31:0]            el_t;
    // scaling helpers
    logic signed [MB-1:0]   diff;
    logic [AW-1:0]          acc_rnd;
    logic [RW-1:0]          scaled;
    logic signed [SW-1:0]   res_wide;
    logic signed [VB:0]     add_from;
    logic signed [VB:0]     add_to;

    assign prog_d = r_clock - r_start;
    assign p_now  = (prog_d == '0 || prog_d[CLOCK_BITS-1]) ? '0 :
                    (prog_d > CLOCK_BITS'(r_len)) ? r_len : DB'(prog_d);

    assign div_sh  = {r_rem, 1'b0};
    assign div_sub = div_sh - {1'b0, r_len};
    assign div_ge  = (div_sh >= {1'b0, r_len});

    assign w_val    = 31'(Q_ONE) - {1'b0, r_quo};
    assign prod_rnd = r_prod + (64'd1 << 29);
    assign el_v     = 34'({r_quo, 1'b0}) + 34'(r_quo) + 34'(r_prod[63:33])
                      - (34'd1 << 28);

    assign idx_scaled = MNW'(r_m) * MNW'(TABLE_ENTRIES) + (MNW'(1) << 29);
    assign j_scaled   = MNW'(r_quo) * MNW'(TABLE_ENTRIES) + (MNW'(1) << 29);
    assign idx_full   = idx_scaled[MNW-1:30];
    assign j_full     = j_scaled[MNW-1:30];

    assign sine_mag = SINE_TAB[r_idx][31] ? 32'(-SINE_TAB[r_idx]) : 32'(SINE_TAB[r_idx]);
    assign el_t     = 32'(r_prod[63:30]);

    assign diff     = MB'(r_to) - MB'(r_from);
    assign acc_rnd  = r_acc + (AW'(1) << 29);
    assign scaled   = acc_rnd[AW-1:30];
    assign res_wide = r_neg ? (SW'(r_from) - $signed({2'b00, scaled}))
                            : (SW'(r_from) + $signed({2'b00, scaled}));

    assign add_from = (VB+1)'(r_from) + (VB+1)'(r_amt);
    assign add_to   = (VB+1)'(r_to) + (VB+1)'(r_amt);

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state  = r_state;
        n_move   = r_move;
        n_clock  = r_clock;
        n_start  = r_start;
        n_len    = r_len;
        n_curve  = r_curve;
        n_from   = r_from;
        n_to     = r_to;
        n_force  = r_force;
        n_last   = r_last;
        n_fseen  = r_fseen;
        n_kind   = r_kind;
        n_icurve = r_icurve;
        n_amt    = r_amt;
        n_dur    = r_dur;
        n_pause  = r_pause;
        n_flags  = r_flags;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_cnt    = r_cnt;
        n_opa    = r_opa;
        n_opb    = r_opb;
        n_prod   = r_prod;
        n_k      = r_k;
        n_m      = r_m;
        n_idx    = r_idx;
        n_j      = r_j;
        n_sneg   = r_sneg;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_acc    = r_acc;
        n_result = r_result;
        o_pop    = 1'b0;
        out_load = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_kind   = i_kind;
                    n_icurve = i_curve;
                    n_amt    = i_amount;
                    n_dur    = i_duration;
                    n_pause  = i_pause;
                    n_state  = S_CMD;
                end
            end
            S_CMD: begin
                n_state = S_FLAGS;
                n_move  = 1'b0;
                case (r_kind)
                    KIND_TICK: begin
                        n_clock = r_clock + 1'b1;
                    end
                    KIND_SET: begin
                        n_force = 1'b1;
                        n_last  = '0;
                        n_curve = CURVE_LINEAR;
                        n_start = '0;
                        n_len   = '0;
                        n_from  = r_amt;
                        n_to    = r_amt;
                        n_fseen = 1'b0;
                    end
                    KIND_ADD: begin
                        n_from  = (add_from[VB] != add_from[VB-1]) ?
                                  (add_from[VB] ? VAL_MIN : VAL_MAX) : VB'(add_from);
                        n_to    = (add_to[VB] != add_to[VB-1]) ?
                                  (add_to[VB] ? VAL_MIN : VAL_MAX) : VB'(add_to);
                        n_force = 1'b1;
                    end
                    KIND_MOVE: begin
                        // value at the moment of the move, from the old tween
                        n_move  = 1'b1;
                        n_state = S_EV0;
                    end
                    default: begin
                    end
                endcase
            end
            S_FLAGS: begin
                n_flags.moved    = r_force || (p_now != r_last);
                n_flags.done     = (p_now == r_len);
                n_flags.finished = !r_fseen && (p_now == r_len);
                n_force          = 1'b0;
                n_last           = p_now;
                if (p_now == r_len) begin
                    n_fseen = 1'b1;
                end
                n_state = S_EV0;
            end
            S_EV0: begin
                if (p_now == '0 || r_len == '0) begin
                    n_result = r_from;
                    n_state  = S_EV_DONE;
                end else if (p_now == r_len) begin
                    n_result = r_to;
                    n_state  = S_EV_DONE;
                end else begin
                    n_rem   = p_now;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // one quotient bit of progress * 2^30 / length per cycle
                n_rem = div_ge ? div_sub[DB-1:0] : div_sh[DB-1:0];
                n_quo = {r_quo[28:0], div_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    n_state = S_CURVE;
                end
            end
            S_CURVE: begin
                n_state = S_C1;
                case (r_curve)
                    CURVE_LINEAR: begin
                        n_k     = {2'b00, r_quo};
                        n_state = S_SCALE0;
                    end
                    CURVE_EASE_IN: begin
                        n_opa = {2'b00, r_quo};
                        n_opb = {2'b00, r_quo};
                    end
                    CURVE_EASE_OUT: begin
                        n_opa = {1'b0, w_val};
                        n_opb = {1'b0, w_val};
                    end
                    default: begin
                        // u / 3 by reciprocal
                        n_opa = {2'b00, r_quo};
                        n_opb = 32'hAAAA_AAAB;
                    end
                endcase
            end
            S_C1: begin
                n_prod  = 64'(r_opa) * 64'(r_opb);
                n_state = S_C2;
            end
            S_C2: begin
                n_state = S_C3;
                if (r_curve == CURVE_ELASTIC) begin
                    n_m = el_v[29:0];
                end else begin
                    n_opa = prod_rnd[61:30];
                    n_opb = (r_curve == CURVE_EASE_IN) ? {2'b00, r_quo} : {1'b0, w_val};
                end
            end
            S_C3: begin
                n_state = S_C4;
                if (r_curve == CURVE_ELASTIC) begin
                    n_idx = (idx_full >= (JW+1)'(TABLE_ENTRIES)) ?
                            IW'(idx_full - (JW+1)'(TABLE_ENTRIES)) : IW'(idx_full);
                    n_j   = (j_full > (JW+1)'(TABLE_ENTRIES)) ?
                            JW'(TABLE_ENTRIES) : JW'(j_full);
                end else begin
                    n_prod = 64'(r_opa) * 64'(r_opb);
                end
            end
            S_C4: begin
                if (r_curve == CURVE_ELASTIC) begin
                    n_opa   = {1'b0, EXP_TAB[r_j]};
                    n_opb   = sine_mag;
                    n_sneg  = SINE_TAB[r_idx][31];
                    n_state = S_C5;
                end else begin
                    n_k     = (r_curve == CURVE_EASE_IN) ? prod_rnd[61:30] :
                              32'(Q_ONE) - prod_rnd[61:30];
                    n_state = S_SCALE0;
                end
            end
            S_C5: begin
                n_prod  = 64'(r_opa) * 64'(r_opb);
                n_state = S_C6;
            end
            S_C6: begin
                n_k     = r_sneg ? 32'(Q_ONE) - el_t : 32'(Q_ONE) + el_t;
                n_state = S_SCALE0;
            end
            S_SCALE0: begin
                n_neg   = diff[MB-1];
                n_mag   = diff[MB-1] ? MB'(-diff) : MB'(diff);
                n_state = S_SCALE1;
            end
            S_SCALE1: begin
                n_acc   = AW'(r_mag[LO-1:0]) * AW'(r_k);
                n_state = S_SCALE2;
            end
            S_SCALE2: begin
                n_prod  = 64'(r_mag[MB-1:LO]) * 64'(r_k);
                n_state = S_SCALE3;
            end
            S_SCALE3: begin
                n_acc   = r_acc + (AW'(r_prod) << LO);
                n_state = S_SCALE4;
            end
            S_SCALE4: begin
                n_result = (res_wide > WIDE_MAX) ? VAL_MAX :
                           (res_wide < WIDE_MIN) ? VAL_MIN : VB'(res_wide);
                n_state  = S_EV_DONE;
            end
            S_EV_DONE: begin
                if (r_move) begin
                    n_from  = r_result;
                    n_to    = r_amt;
                    n_force = 1'b1;
                    n_last  = '0;
                    n_curve = r_icurve;
                    n_len   = r_dur;
                    n_start = r_clock + CLOCK_BITS'(r_pause);
                    n_fseen = 1'b0;
                    n_move  = 1'b0;
                    n_state = S_FLAGS;
                end else if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_move      <= 1'b0;
            r_clock     <= '0;
            r_start     <= '0;
            r_len       <= '0;
            r_curve     <= CURVE_LINEAR;
            r_from      <= '0;
            r_to        <= '0;
            r_force     <= 1'b1;
            r_last      <= '0;
            r_fseen     <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_move  <= n_move;
            r_clock <= n_clock;
            r_start <= n_start;
            r_len   <= n_len;
            r_curve <= n_curve;
            r_from  <= n_from;
            r_to    <= n_to;
            r_force <= n_force;
            r_last  <= n_last;
            r_fseen <= n_fseen;
            r_cnt   <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_icurve <= n_icurve;
        r_amt    <= n_amt;
        r_dur    <= n_dur;
        r_pause  <= n_pause;
        r_flags  <= n_flags;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_opa    <= n_opa;
        r_opb    <= n_opb;
        r_prod   <= n_prod;
        r_k      <= n_k;
        r_m      <= n_m;
        r_idx    <= n_idx;
        r_j      <= n_j;
        r_sneg   <= n_sneg;
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_acc    <= n_acc;
        r_result <= n_result;
        if (out_load) begin
            o_current <= r_result;
            o_target  <= r_to;
            o_flags   <= r_flags;
        end
    end

    assign o_valid = r_out_valid;

    `ETW_ASSERT_IMP(a_pop_idle, o_pop, r_state == S_IDLE, "queue read outside idle")
    `ETW_ASSERT_IMP(a_div_count, r_state == S_DIV, r_cnt < 5'(DIV_STEPS), "divider overran")
    `ETW_ASSERT_IMP(a_fin_done, r_out_valid, !o_flags.finished || o_flags.done, "finished without done")
    `ETW_ASSERT_NXT(a_load_valid, out_load, r_out_valid && r_state == S_IDLE, "result not presented")

endmodule

// File: rtl/eased_tween_interpolator.sv
// an item at rest (progress zero or at its end) skips the divider and the curve steps
// mid-tween it passes the 30-step progress divider plus up to 12 curve and scale steps
// a move's start value needs a full evaluation, its result is at progress zero
// the back end takes one transaction at a time; output stalls hold it before it returns to idle
// reset: synchronous active-low; value, destination and clock clear, queue empties
// ---------------------------------------------------------------------------
// eased_tween_interpolator
// animated q-format value that follows a millisecond tick along easing curves
// ---------------------------------------------------------------------------
module eased_tween_interpolator
    import etw_pkg::*;
#(
    parameter int VALUE_BITS    = VALUE_BITS_DEF,
    parameter int DURATION_BITS = DURATION_BITS_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input transactions
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_mode,
    input  logic [1:0]                    i_curve,
    input  logic signed [VALUE_BITS-1:0]  i_amount,
    input  logic [DURATION_BITS-1:0]      i_duration_ms,
    input  logic [PAUSE_BITS-1:0]         i_pause_ms,
    // result transactions
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_BITS-1:0]  o_current,
    output logic signed [VALUE_BITS-1:0]  o_target,
    output logic                          o_moved,
    output logic                          o_finished,
    output logic                          o_done_res
);

    localparam int QW = KIND_BITS + 2 + VALUE_BITS + DURATION_BITS + PAUSE_BITS;

    // front to queue
    logic                          f_push;
    logic [KIND_BITS-1:0]          f_kind;
    logic [1:0]                    f_curve;
    logic signed [VALUE_BITS-1:0]  f_amount;
    logic [DURATION_BITS-1:0]      f_duration;
    logic [PAUSE_BITS-1:0]         f_pause;
    // queue to back
    logic                          q_full;
    logic                          q_empty;
    logic                          q_pop;
    logic [QW-1:0]                 q_data;
    logic [KIND_BITS-1:0]          b_kind;
    logic [1:0]                    b_curve;
    logic signed [VALUE_BITS-1:0]  b_amount;
    logic [DURATION_BITS-1:0]      b_duration;
    logic [PAUSE_BITS-1:0]         b_pause;
    t_flags                        b_flags;

    // front end: register and classify each transaction
    // (add of zero is a no-op, a move of zero duration is a set)
    etw_front #(
        .VALUE_BITS    (VALUE_BITS),
        .DURATION_BITS (DURATION_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_curve       (i_curve),
        .i_amount      (i_amount),
        .i_duration_ms (i_duration_ms),
        .i_pause_ms    (i_pause_ms),
        .o_push        (f_push),
        .i_full        (q_full),
        .o_kind        (f_kind),
        .o_curve       (f_curve),
        .o_amount      (f_amount),
        .o_duration    (f_duration),
        .o_pause       (f_pause)
    );

    // decoupling queue, lets the front keep accepting while the back computes
    etw_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_kind, f_curve, f_amount, f_duration, f_pause}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    assign {b_kind, b_curve, b_amount, b_duration, b_pause} = q_data;

    // back end: tween state update, progress divider, curve steps, scaling
    etw_back #(
        .VALUE_BITS    (VALUE_BITS),
        .DURATION_BITS (DURATION_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .i_kind     (b_kind),
        .i_curve    (b_curve),
        .i_amount   (b_amount),
        .i_duration (b_duration),
        .i_pause    (b_pause),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_current  (o_current),
        .o_target   (o_target),
        .o_flags    (b_flags)
    );

    assign o_moved    = b_flags.moved;
    assign o_finished = b_flags.finished;
    assign o_done_res = b_flags.done;

endmodule

// File: tb/sv/tween_scoreboard.sv
// ---------------------------------------------------------------------------
// tween_scoreboard
// watches both channels, predicts each result transaction, compares fields
// ---------------------------------------------------------------------------
module tween_scoreboard
    import etw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic [1:0]         i_mode,
    input  logic [1:0]         i_curve,
    input  logic signed [31:0] i_amount,
    input  logic [19:0]        i_duration_ms,
    input  logic [19:0]        i_pause_ms,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic signed [31:0] i_current,
    input  logic signed [31:0] i_target,
    input  logic               i_moved,
    input  logic               i_finished,
    input  logic               i_done_res,
    output int                 o_errors,
    output int                 o_pending
);

    localparam longint ONE_Q30  = 64'sd1 << 30;
    localparam longint PI_Q30   = 64'sd3373259426;
    localparam longint HPI_Q30  = 64'sd1686629713;
    localparam longint TPI_Q30  = 64'sd6746518852;
    localparam longint LN2_Q30  = 64'sd744261118;
    localparam int     N_TAB    = TABLE_ENTRIES_DEF;
    localparam longint VAL_MAX  = 64'sd2147483647;
    localparam longint VAL_MIN  = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] current;
        logic signed [31:0] target;
        logic               moved;
        logic               finished;
        logic               done;
    } tween_res_t;

    longint     sine_lut[N_TAB];
    longint     decay_lut[N_TAB+1];
    tween_res_t expected_q[$];

    // tween state
    bit [31:0]  now_ms, begin_ms;
    longint     span_ms;
    bit [1:0]   shape;
    longint     from_v, to_v;
    bit         force_mv;
    longint     prev_prog;
    bit         fin_seen;

    function automatic longint sine_q30(longint x);
        bit     neg;
        longint term, sum;
        neg = 0;
        if (x >= PI_Q30) begin
            x = x - PI_Q30;
            neg = 1;
        end
        if (x > HPI_Q30) x = PI_Q30 - x;
        term = x;
        sum  = x;
        for (int k = 1; k <= 7; k++) begin
            term = term * x / ONE_Q30;
            term = term * x / ONE_Q30;
            term = -term / ((2 * k) * (2 * k + 1));
            sum += term;
        end
        if (sum < 0) sum = 0;
        if (sum > ONE_Q30) sum = ONE_Q30;
        return neg ? -sum : sum;
    endfunction

    function automatic longint decay_q30(longint j);
        longint e, ip, fr, y, term, sum;
        longint unsigned v;
        e = 10 * j;
        ip = e / N_TAB;
        fr = e % N_TAB;
        y = LN2_Q30 * fr / N_TAB;
        term = ONE_Q30;
        sum = ONE_Q30;
        for (int k = 1; k <= 12; k++) begin
            term = -(term * y / ONE_Q30) / k;
            sum += term;
        end
        if (sum < 0) sum = 0;
        v = sum;
        if (ip > 0) v = (v + (64'd1 << (ip - 1))) >> ip;
        return longint'(v);
    endfunction

    function automatic longint clamp_val(longint v);
        return v > VAL_MAX ? VAL_MAX : (v < VAL_MIN ? VAL_MIN : v);
    endfunction

    // round(diff * k / 2^30) half away from zero, split to stay in 64 bits
    function automatic longint scale_q30(longint diff, longint k);
        bit neg;
        longint unsigned mag, uk, a, b, low, r;
        neg = diff < 0;
        mag = neg ? -diff : diff;
        uk = k;
        a = (mag >> 25) * uk;
        b = (mag & 64'h1FFFFFF) * uk;
        low = ((a & 64'd31) << 25) + b + (64'd1 << 29);
        r = (a >> 5) + (low >> 30);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint progress();
        bit [31:0] d;
        d = now_ms - begin_ms;
        if (d == 0 || d[31]) return 0;
        return (longint'(d) > span_ms) ? span_ms : longint'(d);
    endfunction

    function automatic longint round_mul(longint a, longint b);
        return (a * b + (ONE_Q30 >> 1)) / ONE_Q30;
    endfunction

    function automatic longint eased_value();
        longint p, u, k, w, m, idx, j;
        p = progress();
        if (p == 0 || span_ms == 0) return from_v;
        if (p >= span_ms) return to_v;
        u = (p << 30) / span_ms;
        case (shape)
            CURVE_LINEAR: k = u;
            CURVE_EASE_IN: k = round_mul(round_mul(u, u), u);
            CURVE_EASE_OUT: begin
                w = ONE_Q30 - u;
                k = ONE_Q30 - round_mul(round_mul(w, w), w);
            end
            default: begin
                m = (u * 10 / 3 - ONE_Q30 / 4) % ONE_Q30;
                if (m < 0) m += ONE_Q30;
                idx = (m * N_TAB + ONE_Q30 / 2) / ONE_Q30;
                if (idx >= N_TAB) idx -= N_TAB;
                j = (u * N_TAB + ONE_Q30 / 2) / ONE_Q30;
                if (j > N_TAB) j = N_TAB;
                k = ONE_Q30 + decay_lut[j] * sine_lut[idx] / ONE_Q30;
            end
        endcase
        return clamp_val(from_v + scale_q30(to_v - from_v, k));
    endfunction

    function automatic void jump_to(longint v);
        force_mv = 1;
        prev_prog = 0;
        shape = CURVE_LINEAR;
        begin_ms = 0;
        span_ms = 0;
        from_v = v;
        to_v = v;
        fin_seen = 0;
    endfunction

    function automatic tween_res_t advance(bit [1:0] mode, bit [1:0] crv, longint amt,
                                           longint dur, bit [19:0] pause);
        tween_res_t r;
        longint p;
        case (mode)
            MODE_TICK: now_ms = now_ms + 1;
            MODE_SET: jump_to(amt);
            MODE_ADD: begin
                if (amt != 0) begin
                    from_v = clamp_val(from_v + amt);
                    to_v = clamp_val(to_v + amt);
                    force_mv = 1;
                    prev_prog = progress();
                end
            end
            default: begin
                if (dur == 0) begin
                    jump_to(amt);
                end else begin
                    from_v = eased_value();
                    force_mv = 1;
                    prev_prog = 0;
                    shape = crv;
                    span_ms = dur;
                    begin_ms = now_ms + 32'(pause);
                    to_v = amt;
                    fin_seen = 0;
                end
            end
        endcase
        p = progress();
        if (force_mv) begin
            force_mv = 0;
            r.moved = 1;
        end else begin
            r.moved = (p != prev_prog);
        end
        prev_prog = p;
        r.finished = 0;
        if (!fin_seen && p == span_ms) begin
            fin_seen = 1;
            r.finished = 1;
        end
        r.current = 32'(eased_value());
        r.target = 32'(to_v);
        r.done = (p == span_ms);
        return r;
    endfunction

    initial begin
        for (int i = 0; i < N_TAB; i++) sine_lut[i] = sine_q30(TPI_Q30 * i / N_TAB);
        for (int i = 0; i <= N_TAB; i++) decay_lut[i] = decay_q30(i);
        o_errors = 0;
        now_ms = 0;
        jump_to(0);
    end

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        tween_res_t want;
        if (!i_rst_n) begin
            expected_q.delete();
            now_ms = 0;
            jump_to(0);
        end else begin
            if (i_valid && !i_stall_in)
                expected_q.push_back(advance(i_mode, i_curve, longint'(i_amount),
                                             longint'(i_duration_ms), i_pause_ms));
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result transaction");
                end else begin
                    want = expected_q.pop_front();
                    if (want.current !== i_current || want.target !== i_target ||
                        want.moved !== i_moved || want.finished !== i_finished ||
                        want.done !== i_done_res) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: exp cur %0d tgt %0d mv %b fin %b dn %b, got cur %0d tgt %0d mv %b fin %b dn %b",
                                     want.current, want.target, want.moved, want.finished,
                                     want.done, i_current, i_target, i_moved, i_finished,
                                     i_done_res);
                    end
                end
            end
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// tween interpolator bench: directed corners, then random move/tick sequences
// ---------------------------------------------------------------------------
module tb_top;
    import etw_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_mode;
    logic [1:0]         i_curve;
    logic signed [31:0] i_amount;
    logic [19:0]        i_duration_ms;
    logic [19:0]        i_pause_ms;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_current;
    logic signed [31:0] o_target;
    logic               o_moved;
    logic               o_finished;
    logic               o_done_res;
    int                 errors;
    int                 pending;
    int                 idle_cycles;
    int                 stall_phase;
    int                 stall_level;

    eased_tween_interpolator DUT (.*);

    tween_scoreboard u_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_mode(i_mode), .i_curve(i_curve),
        .i_amount(i_amount), .i_duration_ms(i_duration_ms), .i_pause_ms(i_pause_ms),
        .i_res_valid(o_valid), .i_res_stall(i_stall), .i_current(o_current),
        .i_target(o_target), .i_moved(o_moved), .i_finished(o_finished),
        .i_done_res(o_done_res), .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // receiver stalls in phases: none, light, medium or heavy
    always @(negedge i_clk) begin
        if (stall_phase == 0) begin
            stall_phase = $urandom_range(20, 300);
            stall_level = $urandom_range(0, 3);
        end
        stall_phase--;
        case (stall_level)
            0: i_stall = 1'b0;
            1: i_stall = ($urandom_range(0, 3) == 0);
            2: i_stall = ($urandom_range(0, 1) == 0);
            default: i_stall = ($urandom_range(0, 9) != 0);
        endcase
    end

    // watchdog over cycles where neither channel completes a transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // drive one transaction from the falling edge and hold it until accepted
    task automatic put_item(logic [1:0] mode, logic [1:0] crv, logic [31:0] amt,
                            logic [19:0] dur, logic [19:0] pause);
        @(negedge i_clk);
        i_valid = 1'b1;
        i_mode = mode;
        i_curve = crv;
        i_amount = amt;
        i_duration_ms = dur;
        i_pause_ms = pause;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic go_idle(int cycles);
        @(negedge i_clk);
        i_valid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic tick_run(int count);
        for (int i = 0; i < count; i++) put_item(MODE_TICK, 2'($urandom), $urandom,
                                                 20'($urandom), 20'($urandom));
    endtask

    // random content with a bias toward the range edges
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    int items;
    int burst;
    int len;
    int wait_ms;
    bit burst_mode;

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = MODE_TICK;
        i_curve = CURVE_LINEAR;
        i_amount = '0;
        i_duration_ms = '0;
        i_pause_ms = '0;
        i_stall = 1'b0;
        stall_phase = 0;
        stall_level = 0;
        idle_cycles = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners: idle after reset, saturating adds, each curve, pauses
        put_item(MODE_TICK, CURVE_LINEAR, 0, 0, 0);
        put_item(MODE_ADD, CURVE_LINEAR, 0, 0, 0);
        put_item(MODE_SET, CURVE_ELASTIC, 32'h7FFF_FFFF, 20'hFFFFF, 20'hFFFFF);
        put_item(MODE_ADD, CURVE_LINEAR, 32'h7FFF_FFFF, 0, 0);
        put_item(MODE_SET, CURVE_LINEAR, 32'h8000_0000, 0, 0);
        put_item(MODE_ADD, CURVE_LINEAR, 32'h8000_0000, 0, 0);
        put_item(MODE_MOVE, CURVE_LINEAR, 32'h7FFF_FFFF, 4, 0);
        tick_run(3);
        put_item(MODE_MOVE, CURVE_EASE_IN, 32'h0010_0000, 3, 0);
        tick_run(2);
        put_item(MODE_MOVE, CURVE_EASE_OUT, 32'hFFF0_0000, 3, 2);
        tick_run(2);
        put_item(MODE_ADD, CURVE_LINEAR, 32'h0001_0000, 0, 0);
        tick_run(3);
        put_item(MODE_MOVE, CURVE_ELASTIC, 32'h0100_0000, 5, 0);
        tick_run(5);
        put_item(MODE_MOVE, CURVE_ELASTIC, 32'h1234_5678, 0, 20'hFFFFF);
        put_item(MODE_MOVE, CURVE_LINEAR, 32'h8000_0000, 20'hFFFFF, 0);
        tick_run(1);
        go_idle(0);

        // random: well-formed moves followed by tick runs, with sets, adds and noise
        items = 0;
        burst = 0;
        while (items < 1400) begin
            if (items > 700 && items < 760) begin
                go_idle(0);
                wait (pending == 0);
            end
            case ($urandom_range(0, 9))
                0: begin
                    put_item(MODE_SET, 2'($urandom), rand_value(), 20'($urandom),
                             20'($urandom));
                    items++;
                end
                1: begin
                    put_item(MODE_ADD, 2'($urandom),
                             ($urandom_range(0, 3) == 0) ? rand_value()
                                 : 32'($signed($urandom_range(0, 200)) - 100) <<< 16,
                             20'($urandom), 20'($urandom));
                    items++;
                end
                default: begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                       : $urandom_range(0, 40);
                    wait_ms = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                           : $urandom_range(0, 6);
                    put_item(MODE_MOVE, 2'($urandom), rand_value(), 20'(len),
                             20'(wait_ms));
                    items++;
                    len = $urandom_range(0, ((len > 40) ? 40 : len) + 8);
                    for (int i = 0; i < len; i++) begin
                        if (burst == 0) begin
                            burst_mode = $urandom_range(0, 3) != 0;
                            burst = $urandom_range(1, 30);
                            if (burst_mode) go_idle($urandom_range(1, 12));
                        end
                        burst--;
                        if ($urandom_range(0, 19) == 0)
                            put_item(MODE_ADD, 2'($urandom), rand_value(), 0, 0);
                        else
                            put_item(MODE_TICK, 2'($urandom), $urandom, 20'($urandom),
                                     20'($urandom));
                        items++;
                    end
                end
            endcase
        end
        go_idle(0);

        wait (pending == 0);
        repeat (120) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// File: eased_tween_interpolator.f
+incdir+rtl
rtl/etw_pkg.sv
rtl/etw_front.sv
rtl/etw_queue.sv
rtl/etw_back.sv
rtl/eased_tween_interpolator.sv
tb/sv/tween_scoreboard.sv
tb/sv/tb_top.sv
